/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions for the SHA-256 stream unit
// Holds the item structs, controller states, command/status bundles and the
// round constant table.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic KindData   = 1'b0;
    localparam logic KindFinish = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // byte source for a buffer write
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic       buf_wr;
        t_src       buf_src;
        logic [5:0] buf_addr;
        logic       cnt_inc;
        logic       load;
        logic       round;
        logic       add;
        logic       emit_shift;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_status;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* sv/sha_ctrl.sv */
// ----------------------------------------------------------------------------
// sha_ctrl: sequencer for the SHA-256 stream unit
// Accepts items, walks padding, compression rounds, chain add and digest emit.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sha_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sha_pkg::t_status  i_status,
    output sha_pkg::t_cmd     o_cmd
);

    sha_pkg::t_state r_state, n_state;
    logic [5:0]      r_step, n_step;   // pad address, round index or word index
    logic            r_final, n_final; // this compression ends the message
    logic            r_pad_next;       // padding spills into a second block
    logic            w_acc;
    logic            w_out_acc;

    assign w_acc     = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_final = r_final;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_item.kind == sha_pkg::KindFinish) begin
                        n_state = sha_pkg::ST_PAD;
                        n_step  = i_status.pos + 6'd1;
                        n_final = (i_status.pos < 6'(sha_pkg::LenPos));
                        if (i_status.pos == 6'd63) begin
                            n_state = sha_pkg::ST_LOAD;
                        end
                    end else if (i_status.pos == 6'd63) begin
                        n_state = sha_pkg::ST_LOAD;
                        n_final = 1'b0;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'd63) begin
                    n_state = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD: begin
                n_state = sha_pkg::ST_ROUND;
                n_step  = 6'd0;
            end
            sha_pkg::ST_ROUND: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'd63) begin
                    n_state = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                n_step = 6'd0;
                if (r_final) begin
                    n_state = sha_pkg::ST_EMIT;
                end else if (r_pad_next) begin
                    // second padding block: zeros up to the length field
                    n_state = sha_pkg::ST_PAD;
                    n_final = 1'b1;
                end else begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (w_out_acc) begin
                    n_step = r_step + 6'd1;
                    if (r_step[2:0] == 3'd7) begin
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.buf_src  = sha_pkg::SRC_DATA;
        o_cmd.buf_addr = r_step;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.buf_addr = i_status.pos;
                o_cmd.buf_wr   = w_acc;
                o_cmd.buf_src  = (i_in_item.kind == sha_pkg::KindFinish) ?
                                 sha_pkg::SRC_PAD : sha_pkg::SRC_DATA;
                o_cmd.cnt_inc  = w_acc && (i_in_item.kind == sha_pkg::KindData);
            end
            sha_pkg::ST_PAD: begin
                o_cmd.buf_wr  = 1'b1;
                o_cmd.buf_src = (r_final && r_step >= 6'(sha_pkg::LenPos)) ?
                                sha_pkg::SRC_LEN : sha_pkg::SRC_ZERO;
            end
            sha_pkg::ST_LOAD:  o_cmd.load = 1'b1;
            sha_pkg::ST_ROUND: o_cmd.round = 1'b1;
            sha_pkg::ST_ADD:   o_cmd.add = 1'b1;
            sha_pkg::ST_EMIT: begin
                o_out_valid      = 1'b1;
                o_cmd.emit_shift = w_out_acc;
                o_cmd.clear      = w_out_acc && (r_step[2:0] == 3'd7);
            end
            default: ;
        endcase
    end

    // after a non-final block that came from padding, pad the next block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_next <= 1'b0;
        end else if (r_state == sha_pkg::ST_IDLE && w_acc) begin
            r_pad_next <= (i_in_item.kind == sha_pkg::KindFinish) &&
                          (i_status.pos >= 6'(sha_pkg::LenPos));
        end else if (r_state == sha_pkg::ST_ADD) begin
            r_pad_next <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            r_step  <= 6'd0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_final <= n_final;
        end
    end

    a_emit_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("output and input open together");
    a_round_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::ST_LOAD) |=> (r_state == sha_pkg::ST_ROUND && r_step == 6'd0))
        else $error("rounds did not start at zero");
    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> (r_state == sha_pkg::ST_IDLE)) else $error("clear not at end");

endmodule

/* sv/sha_dpath.sv */
// ----------------------------------------------------------------------------
// sha_dpath: datapath for the SHA-256 stream unit
// Byte packing into the message schedule window, byte count, one-round
// compression core and chain value with digest shift-out.
// ----------------------------------------------------------------------------
module sha_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_cmd     i_cmd,
    input  sha_pkg::t_in_item i_in_item,
    output sha_pkg::t_status  o_status,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index
);

    logic [60:0] r_count;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [2:0]  r_widx;
    logic [63:0] w_bits;
    logic [7:0]  w_byte;
    logic [31:0] w_wi, w_t1, w_t2, w_s0, w_s1, w_e, w_a;

    assign o_status.pos = r_count[5:0];
    assign w_bits       = {r_count, 3'b000};

    // select the byte written into the block
    always_comb begin
        case (i_cmd.buf_src)
            sha_pkg::SRC_DATA: w_byte = i_in_item.data_byte;
            sha_pkg::SRC_PAD:  w_byte = sha_pkg::PadByte;
            sha_pkg::SRC_ZERO: w_byte = 8'h00;
            default:           w_byte = w_bits[8 * (7 - int'(i_cmd.buf_addr[2:0])) +: 8];
        endcase
    end

    // advance the byte count; reset it once the digest is out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + 61'd1;
        end
    end

    // schedule word for this round
    always_comb begin
        w_s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_wi = (r_rnd < 6'd16) ? r_w[0] : (w_s1 + r_w[9] + w_s0 + r_w[0]);
        w_e  = r_v[4];
        w_a  = r_v[0];
        w_t1 = r_v[7] + (sha_pkg::rotr(w_e, 6) ^ sha_pkg::rotr(w_e, 11) ^
               sha_pkg::rotr(w_e, 25)) + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) +
               sha_pkg::RoundK[r_rnd] + w_wi;
        w_t2 = (sha_pkg::rotr(w_a, 2) ^ sha_pkg::rotr(w_a, 13) ^ sha_pkg::rotr(w_a, 22)) +
               ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // pack bytes big-endian into the window; during rounds it rotates, slot 0
    // holding w[i] in rounds 0-15 and w[i-16] from round 16 on
    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            r_w[i_cmd.buf_addr[5:2]][8 * (3 - int'(i_cmd.buf_addr[1:0])) +: 8] <= w_byte;
        end else if (i_cmd.load) begin
            r_rnd <= 6'd0;
            for (int k = 0; k < 8; k++) begin
                r_v[k] <= r_h[k];
            end
        end else if (i_cmd.round) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= w_wi;
            r_rnd   <= r_rnd + 6'd1;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // chain value: add, rotate out for emit, reset at message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < 8; k++) begin
                r_h[k] <= sha_pkg::InitHash[k];
            end
            r_widx <= 3'd0;
        end else if (i_cmd.add) begin
            for (int k = 0; k < 8; k++) begin
                r_h[k] <= r_h[k] + r_v[k];
            end
            r_widx <= 3'd0;
        end else if (i_cmd.emit_shift) begin
            for (int k = 0; k < 7; k++) begin
                r_h[k] <= r_h[k+1];
            end
            r_h[7] <= r_h[0];
            r_widx <= r_widx + 3'd1;
        end
    end

    assign o_digest_word = r_h[0];
    assign o_word_index  = r_widx;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.round && i_cmd.load)) else $error("load during rounds");
    a_round_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |-> $past(i_cmd.round) && $past(r_rnd) == 6'd63)
        else $error("add before round 63");
    a_clear_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> r_widx == 3'd7) else $error("clear at wrong word");

endmodule

/* sv/sha256_stream_hash_unit.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hash_unit: streaming SHA-256 hash
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) carries one item per
//   handshake: a data byte (kind 0) or a finish (kind 1).
//   Output channel (o_out_valid/i_out_ready, o_out_item) carries the eight
//   digest words of a message, word 0 first, last_word set on word 7.
//   A data byte is written into the block on its handshake; the 64th byte of
//   a block then holds the input through the load, the 64 rounds of the
//   single shared round unit, and the chain add.
//   A finish item writes the padding one byte a cycle up to byte 63, runs
//   the compression, and when the length does not fit, pads and compresses a
//   second block; then the eight words follow, one a cycle while the receiver
//   takes them. A stalled receiver holds the current word; no new item is
//   taken until word 7 is accepted.
//   Synchronous reset loads the initial hash values and clears the count.
// ----------------------------------------------------------------------------
module sha256_stream_hash_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sha_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sha_pkg::t_out_item o_out_item
);

    sha_pkg::t_cmd    w_cmd;
    sha_pkg::t_status w_status;
    logic [31:0]      w_word;
    logic [2:0]       w_idx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sha_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_item     (i_in_item),
        .o_status      (w_status),
        .o_digest_word (w_word),
        .o_word_index  (w_idx)
    );

    assign o_out_item.digest_word = w_word;
    assign o_out_item.word_index  = w_idx;
    assign o_out_item.last_word   = (w_idx == 3'd7);

endmodule

/* test/sha256_stream_hash_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hash_unit_tb: self-checking bench for the SHA-256 stream unit
// Drives message bytes and finish items through the input handshake, keeps
// a software copy of the hash state to predict each digest, and compares
// every digest word taken from the output channel against the prediction.
// ----------------------------------------------------------------------------
module sha256_stream_hash_unit_tb;

    localparam int unsigned WatchdogLimit = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sha_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    sha_pkg::t_out_item o_out_item;

    // predicted hash state
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    sha_pkg::t_out_item digest_queue [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          sink_idle_enable;
    bit          sink_hold;
    bit          src_idle_enable;

    sha256_stream_hash_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // run the 64 rounds over the predicted block and fold into the chain
    task automatic compress_predicted();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wi, t1, t2, x2, x15, e, a;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int j = 0; j < 8; j++)
            v[j] = hash_chain[j];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                wi = w[i];
            end else begin
                x2  = w[(i - 2) & 15];
                x15 = w[(i - 15) & 15];
                wi = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + w[(i - 7) & 15]
                   + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[i & 15];
                w[i & 15] = wi;
            end
            e = v[4];
            a = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + sha_pkg::RoundK[i] + wi;
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_chain[j] = hash_chain[j] + v[j];
    endtask

    task automatic restart_message();
        for (int j = 0; j < 8; j++)
            hash_chain[j] = sha_pkg::InitHash[j];
        for (int j = 0; j < 64; j++)
            msg_block[j] = 8'h00;
        msg_bytes = '0;
    endtask

    // update prediction for one accepted item, queue digest words on finish
    task automatic predict_hash(input sha_pkg::t_in_item item);
        logic [63:0] bit_len;
        int pos;
        sha_pkg::t_out_item word;
        pos = int'(msg_bytes[5:0]);
        if (item.kind == sha_pkg::KindData) begin
            msg_block[pos] = item.data_byte;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 63)
                compress_predicted();
        end else begin
            bit_len = {msg_bytes, 3'b000};
            msg_block[pos] = sha_pkg::PadByte;
            pos++;
            if (pos > int'(sha_pkg::LenPos)) begin
                while (pos < 64) msg_block[pos++] = 8'h00;
                compress_predicted();
                pos = 0;
            end
            while (pos < int'(sha_pkg::LenPos)) msg_block[pos++] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[63 - i] = bit_len[8*i +: 8];
            compress_predicted();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_chain[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                digest_queue.push_back(word);
            end
            restart_message();
        end
    endtask

    // offer one item, hold it until accepted, with optional random gap before
    task automatic send_item(input logic kind, input logic [7:0] data);
        sha_pkg::t_in_item item;
        int gap;
        item.kind = kind;
        item.data_byte = data;
        if (src_idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_hash(item);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(sha_pkg::KindData, 8'($urandom));
        send_item(sha_pkg::KindFinish, 8'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    // empty message, one-byte message, byte extremes
    task automatic test_directed();
        send_item(sha_pkg::KindFinish, 8'hFF);
        send_item(sha_pkg::KindData, 8'h00);
        send_item(sha_pkg::KindFinish, 8'h00);
        send_item(sha_pkg::KindData, 8'hFF);
        send_item(sha_pkg::KindData, 8'h55);
        send_item(sha_pkg::KindData, 8'hAA);
        send_item(sha_pkg::KindFinish, 8'h5A);
        wait_drained();
    endtask

    // finish in the last byte of a block, and a full block plus 56 bytes followed
    // by a finish that pushes the length into a second block
    task automatic test_pad_boundaries();
        send_message(63);
        send_message(120);
        wait_drained();
    endtask

    // random short message lengths with random idling on both sides
    task automatic test_random_messages(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total) begin
            len = $urandom_range(0, 12);
            send_message(len);
            sent += len + 1;
        end
    endtask

    // stall the receiver long enough that the input side backs up
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                send_message(4);
                send_message(4);
                i_in_valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    // check each accepted digest word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected word, actual %h/%0d/%b", $time,
                         o_out_item.digest_word, o_out_item.word_index,
                         o_out_item.last_word);
                error_count++;
            end else if (o_out_item !== digest_queue[0]) begin
                $display("%0t: mismatch, expected %h/%0d/%b, actual %h/%0d/%b", $time,
                         digest_queue[0].digest_word, digest_queue[0].word_index,
                         digest_queue[0].last_word, o_out_item.digest_word,
                         o_out_item.word_index, o_out_item.last_word);
                error_count++;
                void'(digest_queue.pop_front());
            end else begin
                void'(digest_queue.pop_front());
            end
        end
    end

    // drive receiver ready with bursts of idling
    initial begin
        int burst;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                i_out_ready <= 1'b0;
                @(posedge i_clk);
            end else if (sink_idle_enable && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 10);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("sha256_stream_hash_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        sink_idle_enable = 1'b1;
        sink_hold        = 1'b0;
        src_idle_enable  = 1'b1;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        restart_message();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_messages(15);
        wait_drained();
        sink_idle_enable = 1'b0;
        src_idle_enable  = 1'b0;
        test_pad_boundaries();
        repeat (200) @(posedge i_clk);

        if (error_count == 0 && digest_queue.size() == 0)
            $display("sha256_stream_hash_unit_tb: clean");
        else
            $display("sha256_stream_hash_unit_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
sv/sha_pkg.sv
sv/sha_ctrl.sv
sv/sha_dpath.sv
sv/sha256_stream_hash_unit.sv
test/sha256_stream_hash_unit_tb.sv
